/* hdl/sbc_pkg.sv */
// sbc_pkg: types, widths and constants for the swept box collision test
// shared by every module of the block except sbc_fifo; depends on nothing
`default_nettype none

package sbc_pkg;

   // field widths
   localparam int COORD_BITS     = 16;
   localparam int TIME_FRAC_BITS = 15;
   localparam int SPEED_BITS     = 16;
   localparam int FT_BITS        = 8;
   localparam logic [FT_BITS-1:0] FT_RESET = 8'd16;

   // displacement = speed * ft * 256 / 1000 = speed * ft * 32 / 125
   localparam int PROD_BITS    = 23;          // |speed| * ft < 2^23
   localparam int SCALE_SHIFT  = 5;
   localparam int DISP_DIV     = 125;
   localparam int RECIP_BITS   = 27;
   localparam logic [RECIP_BITS-1:0] RECIP = 27'd68719476;  // floor(2^33 / 125)
   localparam int RECIP_SHIFT  = 28;
   localparam int MAG_BITS     = 22;
   localparam int DISP_BITS    = MAG_BITS + 1;
   localparam int FIX_BITS     = PROD_BITS + SCALE_SHIFT + 1;

   // broadphase and relative motion widths
   localparam int EDGE_BITS = COORD_BITS + 10;
   localparam int VEL_BITS  = DISP_BITS + 1;
   localparam int DIST_BITS = COORD_BITS + 1;
   localparam int AV_BITS   = VEL_BITS - 1;
   localparam int REM_BITS  = AV_BITS + 1;

   // time values
   localparam int Q_BITS     = TIME_FRAC_BITS + 1;
   localparam int TIME_BITS  = TIME_FRAC_BITS + 3;
   localparam int T_ONE_INT  = 1 << TIME_FRAC_BITS;
   localparam logic signed [TIME_BITS-1:0] T_ONE   = TIME_BITS'(T_ONE_INT);
   localparam logic signed [TIME_BITS-1:0] T_LIM   = TIME_BITS'(2 * T_ONE_INT);
   localparam logic signed [TIME_BITS-1:0] NEG_LIM = -TIME_BITS'(2 * T_ONE_INT);

   typedef enum logic [2:0] {
      SIDE_NONE   = 3'd0,
      SIDE_LEFT   = 3'd1,
      SIDE_RIGHT  = 3'd2,
      SIDE_TOP    = 3'd3,
      SIDE_BOTTOM = 3'd4
   } side_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] mine_left;
      logic signed [COORD_BITS-1:0] mine_top;
      logic signed [COORD_BITS-1:0] mine_right;
      logic signed [COORD_BITS-1:0] mine_bottom;
      logic signed [COORD_BITS-1:0] other_left;
      logic signed [COORD_BITS-1:0] other_top;
      logic signed [COORD_BITS-1:0] other_right;
      logic signed [COORD_BITS-1:0] other_bottom;
      logic signed [SPEED_BITS-1:0] mine_speed_x;
      logic signed [SPEED_BITS-1:0] mine_speed_y;
      logic signed [SPEED_BITS-1:0] other_speed_x;
      logic signed [SPEED_BITS-1:0] other_speed_y;
   } req_type;

   typedef struct packed {
      logic [TIME_FRAC_BITS:0] entry_time;
      logic [2:0]              hit_side;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                        miss;
      logic                        vx_zero;
      logic                        vy_zero;
      logic signed [VEL_BITS-1:0]  vx;
      logic signed [VEL_BITS-1:0]  vy;
      logic signed [DIST_BITS-1:0] dx_entry;
      logic signed [DIST_BITS-1:0] dx_exit;
      logic signed [DIST_BITS-1:0] dy_entry;
      logic signed [DIST_BITS-1:0] dy_exit;
   } task_type;

   // side information riding alongside the dividers
   typedef struct packed {
      logic miss;
      logic vx_zero;
      logic vy_zero;
      logic dx_neg;
      logic dy_neg;
   } tag_type;

   // pixel coordinate to 8 fraction bits
   function automatic logic signed [EDGE_BITS-1:0] scale_edge(
      input logic signed [COORD_BITS-1:0] c);
      scale_edge = {{(EDGE_BITS-COORD_BITS-8){c[COORD_BITS-1]}}, c, 8'b0};
   endfunction

endpackage

`default_nettype wire

/* hdl/sbc_fifo.sv */
// sbc_fifo: small first-word-fall-through queue of packed words
// standalone; used for the task queue and the result queue
`default_nettype none

module sbc_fifo #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0]   store_ff [0:DEPTH-1];
   logic [ADDR_BITS:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_BITS:0] rd_ptr_ff, rd_ptr_in;

   // pointer compare with wrap bit
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[ADDR_BITS-1:0] == rd_ptr_ff[ADDR_BITS-1:0]) &&
                  (wr_ptr_ff[ADDR_BITS] != rd_ptr_ff[ADDR_BITS]);
   assign pop_data = store_ff[rd_ptr_ff[ADDR_BITS-1:0]];

   assign wr_ptr_in = wr_ptr_ff + ((push && !full) ? 1'b1 : 1'b0);
   assign rd_ptr_in = rd_ptr_ff + ((pop && !empty) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push && !full) begin
         store_ff[wr_ptr_ff[ADDR_BITS-1:0]] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/sbc_front.sv */
// sbc_front: displacement scaling, broadphase test and per-axis classification
// depends on sbc_pkg
`default_nettype none

module sbc_front
   import sbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  req_type            in_item,
   input  logic [FT_BITS-1:0] frame_time,
   output logic               out_valid,
   output task_type           out_task
);

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   req_type              s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff;
   logic [PROD_BITS-1:0] prod_ff [0:3];
   logic [PROD_BITS-1:0] prod3_ff [0:3];
   logic [MAG_BITS-1:0]  est_ff [0:3];
   logic [3:0]           neg2_ff, neg3_ff;
   logic signed [DISP_BITS-1:0] disp_ff [0:3];

   logic signed [SPEED_BITS-1:0] speed [0:3];
   logic [PROD_BITS-1:0]         prod_in [0:3];
   logic [MAG_BITS-1:0]          est_in [0:3];
   logic signed [DISP_BITS-1:0]  disp_in [0:3];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign speed[0] = s1_item_ff.mine_speed_x;
   assign speed[1] = s1_item_ff.mine_speed_y;
   assign speed[2] = s1_item_ff.other_speed_x;
   assign speed[3] = s1_item_ff.other_speed_y;

   // speed magnitude times frame time, reciprocal estimate, then one correction
   always_comb begin
      logic [SPEED_BITS:0]              mag;
      logic [PROD_BITS+RECIP_BITS-1:0]  wide;
      logic [FIX_BITS-1:0]              rem;
      logic [MAG_BITS-1:0]              q;
      for (int i = 0; i < 4; i++) begin
         mag = speed[i][SPEED_BITS-1] ? -(SPEED_BITS+1)'(speed[i])
                                     : (SPEED_BITS+1)'(speed[i]);
         prod_in[i] = PROD_BITS'(mag) * PROD_BITS'(frame_time);
         wide = (PROD_BITS+RECIP_BITS)'(prod_ff[i]) * (PROD_BITS+RECIP_BITS)'(RECIP);
         est_in[i] = MAG_BITS'(wide >> RECIP_SHIFT);
         rem = FIX_BITS'({prod3_ff[i], {SCALE_SHIFT{1'b0}}}) -
               FIX_BITS'(est_ff[i]) * FIX_BITS'(DISP_DIV);
         q = est_ff[i] + ((rem >= FIX_BITS'(DISP_DIV)) ? 1'b1 : 1'b0);
         disp_in[i] = neg3_ff[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= in_item;
         s2_item_ff <= s1_item_ff;
         s3_item_ff <= s2_item_ff;
         s4_item_ff <= s3_item_ff;
         for (int i = 0; i < 4; i++) begin
            prod_ff[i]  <= prod_in[i];
            neg2_ff[i]  <= speed[i][SPEED_BITS-1];
            prod3_ff[i] <= prod_ff[i];
            est_ff[i]   <= est_in[i];
            neg3_ff[i]  <= neg2_ff[i];
            disp_ff[i]  <= disp_in[i];
         end
      end
   end

   // broadphase box of the mover against the other box, touching counts
   logic signed [EDGE_BITS-1:0] mdx, mdy, bl, br, bt, bb;
   logic signed [VEL_BITS-1:0]  vx, vy;

   always_comb begin
      mdx = EDGE_BITS'(disp_ff[0]);
      mdy = EDGE_BITS'(disp_ff[1]);
      bt  = scale_edge(s4_item_ff.mine_top)    + ((mdy > 0) ? mdy : '0);
      bb  = scale_edge(s4_item_ff.mine_bottom) + ((mdy > 0) ? '0 : mdy);
      bl  = scale_edge(s4_item_ff.mine_left)   + ((mdx > 0) ? '0 : mdx);
      br  = scale_edge(s4_item_ff.mine_right)  + ((mdx > 0) ? mdx : '0);
      vx  = VEL_BITS'(disp_ff[0]) - VEL_BITS'(disp_ff[2]);
      vy  = VEL_BITS'(disp_ff[1]) - VEL_BITS'(disp_ff[3]);

      out_task.miss = (scale_edge(s4_item_ff.other_left)   > br) ||
                      (scale_edge(s4_item_ff.other_right)  < bl) ||
                      (scale_edge(s4_item_ff.other_top)    < bb) ||
                      (scale_edge(s4_item_ff.other_bottom) > bt);
      out_task.vx      = vx;
      out_task.vy      = vy;
      out_task.vx_zero = (vx == '0);
      out_task.vy_zero = (vy == '0);

      // entry and exit distances by direction of relative motion
      if (vx > 0) begin
         out_task.dx_entry = DIST_BITS'(s4_item_ff.other_left) -
                             DIST_BITS'(s4_item_ff.mine_right);
         out_task.dx_exit  = DIST_BITS'(s4_item_ff.other_right) -
                             DIST_BITS'(s4_item_ff.mine_left);
      end else begin
         out_task.dx_entry = DIST_BITS'(s4_item_ff.other_right) -
                             DIST_BITS'(s4_item_ff.mine_left);
         out_task.dx_exit  = DIST_BITS'(s4_item_ff.other_left) -
                             DIST_BITS'(s4_item_ff.mine_right);
      end
      if (vy > 0) begin
         out_task.dy_entry = DIST_BITS'(s4_item_ff.other_bottom) -
                             DIST_BITS'(s4_item_ff.mine_top);
         out_task.dy_exit  = DIST_BITS'(s4_item_ff.other_top) -
                             DIST_BITS'(s4_item_ff.mine_bottom);
      end else begin
         out_task.dy_entry = DIST_BITS'(s4_item_ff.other_top) -
                             DIST_BITS'(s4_item_ff.mine_bottom);
         out_task.dy_exit  = DIST_BITS'(s4_item_ff.other_bottom) -
                             DIST_BITS'(s4_item_ff.mine_top);
      end
   end

   assign out_valid = s4_valid_ff;

endmodule

`default_nettype wire

/* hdl/sbc_divider.sv */
// sbc_divider: pipelined restoring divide of a pixel distance by a displacement
// one quotient bit per stage after a setup stage, saturating to +-2.0; depends on sbc_pkg
`default_nettype none

module sbc_divider
   import sbc_pkg::*;
(
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [DIST_BITS-1:0] distance,
   input  logic signed [VEL_BITS-1:0]  divisor,
   output logic signed [TIME_BITS-1:0] quotient
);

   localparam int PRE_SHIFT = 8 + TIME_FRAC_BITS - Q_BITS;

   logic [REM_BITS-1:0] rem_ff [0:Q_BITS];
   logic [AV_BITS-1:0]  av_ff  [0:Q_BITS];
   logic [Q_BITS-1:0]   q_ff   [0:Q_BITS];
   logic                neg_ff [0:Q_BITS];
   logic                sat_ff [0:Q_BITS];

   logic [DIST_BITS-1:0] dist_mag;
   logic [VEL_BITS-1:0]  v_mag;
   logic [REM_BITS-1:0]  rem0;

   // magnitudes, sign and saturation test
   assign dist_mag = distance[DIST_BITS-1] ? DIST_BITS'(-distance) : DIST_BITS'(distance);
   assign v_mag    = divisor[VEL_BITS-1] ? VEL_BITS'(-divisor) : VEL_BITS'(divisor);
   assign rem0     = REM_BITS'({dist_mag[DIST_BITS-2:0], {PRE_SHIFT{1'b0}}});

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= rem0;
         av_ff[0]  <= v_mag[AV_BITS-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= distance[DIST_BITS-1] != divisor[VEL_BITS-1];
         sat_ff[0] <= rem0 >= REM_BITS'(v_mag[AV_BITS-1:0]);
      end
   end

   // one shift and trial subtract per stage
   for (genvar k = 1; k <= Q_BITS; k++) begin : g_stage
      logic [REM_BITS-1:0] trial;
      logic                take;
      assign trial = {rem_ff[k-1][REM_BITS-2:0], 1'b0};
      assign take  = trial >= {1'b0, av_ff[k-1]};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= take ? trial - {1'b0, av_ff[k-1]} : trial;
            q_ff[k]   <= {q_ff[k-1][Q_BITS-2:0], take};
            av_ff[k]  <= av_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   logic signed [TIME_BITS-1:0] mag;
   assign mag      = sat_ff[Q_BITS] ? T_LIM : $signed(TIME_BITS'(q_ff[Q_BITS]));
   assign quotient = neg_ff[Q_BITS] ? -mag : mag;

endmodule

`default_nettype wire

/* hdl/sbc_back.sv */
// sbc_back: four time dividers and the final entry/exit decision
// depends on sbc_pkg and sbc_divider
`default_nettype none

module sbc_back
   import sbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  task_type in_task,
   output logic     out_valid,
   output rsp_type  out_item
);

   localparam int DEPTH = Q_BITS + 1;

   logic    valid_ff [0:DEPTH-1];
   tag_type tag_ff   [0:DEPTH-1];
   tag_type tag_in;

   logic signed [TIME_BITS-1:0] tx_entry, tx_exit, ty_entry, ty_exit;

   sbc_divider u_div_xe (.clock, .advance, .distance(in_task.dx_entry),
                         .divisor(in_task.vx), .quotient(tx_entry));
   sbc_divider u_div_xx (.clock, .advance, .distance(in_task.dx_exit),
                         .divisor(in_task.vx), .quotient(tx_exit));
   sbc_divider u_div_ye (.clock, .advance, .distance(in_task.dy_entry),
                         .divisor(in_task.vy), .quotient(ty_entry));
   sbc_divider u_div_yx (.clock, .advance, .distance(in_task.dy_exit),
                         .divisor(in_task.vy), .quotient(ty_exit));

   assign tag_in.miss    = in_task.miss;
   assign tag_in.vx_zero = in_task.vx_zero;
   assign tag_in.vy_zero = in_task.vy_zero;
   assign tag_in.dx_neg  = in_task.dx_entry[DIST_BITS-1];
   assign tag_in.dy_neg  = in_task.dy_entry[DIST_BITS-1];

   // tags and valid bits shadow the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < DEPTH; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   // zero motion stands for infinite times, then latest entry against earliest exit
   logic signed [TIME_BITS-1:0] txe, txx, tye, tyx, entry, leave;
   logic                        no_hit;
   tag_type                     tag;

   always_comb begin
      tag   = tag_ff[DEPTH-1];
      txe   = tag.vx_zero ? NEG_LIM : tx_entry;
      txx   = tag.vx_zero ? T_LIM   : tx_exit;
      tye   = tag.vy_zero ? NEG_LIM : ty_entry;
      tyx   = tag.vy_zero ? T_LIM   : ty_exit;
      entry = (txe > tye) ? txe : tye;
      leave = (txx < tyx) ? txx : tyx;
      no_hit = tag.miss || (entry > leave) || (txe < 0 && tye < 0) ||
               (txe > T_ONE) || (tye > T_ONE);
      if (no_hit) begin
         out_item.entry_time = T_ONE[TIME_FRAC_BITS:0];
         out_item.hit_side   = SIDE_NONE;
      end else begin
         out_item.entry_time = entry[TIME_FRAC_BITS:0];
         if (txe > tye) begin
            out_item.hit_side = tag.dx_neg ? SIDE_RIGHT : SIDE_LEFT;
         end else begin
            out_item.hit_side = tag.dy_neg ? SIDE_TOP : SIDE_BOTTOM;
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];

endmodule

`default_nettype wire

/* hdl/swept_box_collision_test.sv */
// swept_box_collision_test: top level of the swept box collision test
// depends on sbc_pkg, sbc_fifo, sbc_front and sbc_back
//
//   channel   ports                               moves
//   request   push, full, req_item                one body pair per item
//   response  empty, pop, rsp_item                entry time and side hit
//   csr       csr_write_enable, csr_write_data    frame time in ms
//
// one item per cycle while neither queue is full; items pass 4 front stages, the task queue,
// 17 divider stages (a setup stage, then one quotient bit per stage) and the result queue
// full rises only when the task queue is full; the front then holds
// a stalled result queue freezes the divider pipeline, never loses an item
// reset clears all valid state and loads frame time 16 ms
`default_nettype none

module swept_box_collision_test
   import sbc_pkg::*;
#(
   parameter int TASK_ADDR_BITS = 2,
   parameter int RSP_ADDR_BITS  = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  req_type            req_item,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_item,
   input  logic               csr_write_enable,
   input  logic [FT_BITS-1:0] csr_write_data
);

   logic [FT_BITS-1:0] frame_time_ff;

   // frame time register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= FT_RESET;
      end else if (csr_write_enable) begin
         frame_time_ff <= csr_write_data;
      end
   end

   logic     task_full, task_empty, front_valid, back_valid, rsp_full;
   logic     front_adv, back_adv, task_pop;
   task_type front_task, back_task;
   rsp_type  back_item;

   assign front_adv = !task_full;
   assign full      = task_full;
   assign back_adv  = !rsp_full;
   assign task_pop  = back_adv && !task_empty;

   sbc_front u_front (
      .clock, .reset,
      .advance    (front_adv),
      .in_valid   (push),
      .in_item    (req_item),
      .frame_time (frame_time_ff),
      .out_valid  (front_valid),
      .out_task   (front_task)
   );

   sbc_fifo #(.WIDTH($bits(task_type)), .ADDR_BITS(TASK_ADDR_BITS)) u_task_q (
      .clock, .reset,
      .push      (front_valid && front_adv),
      .push_data (front_task),
      .full      (task_full),
      .pop       (task_pop),
      .pop_data  (back_task),
      .empty     (task_empty)
   );

   sbc_back u_back (
      .clock, .reset,
      .advance   (back_adv),
      .in_valid  (task_pop),
      .in_task   (back_task),
      .out_valid (back_valid),
      .out_item  (back_item)
   );

   sbc_fifo #(.WIDTH($bits(rsp_type)), .ADDR_BITS(RSP_ADDR_BITS)) u_rsp_q (
      .clock, .reset,
      .push      (back_valid && back_adv),
      .push_data (back_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

   // a result never claims a time beyond one frame
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_item.entry_time <= T_ONE[TIME_FRAC_BITS:0])
      else $error("entry time beyond one frame");

   // a miss always reports the full frame
   a_miss_time: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.hit_side == SIDE_NONE) |->
         rsp_item.entry_time == T_ONE[TIME_FRAC_BITS:0])
      else $error("miss with partial entry time");

   // a frame time write lands in the register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> frame_time_ff == $past(csr_write_data))
      else $error("frame time write lost");

   // the back end never finishes an item into a full result queue
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (back_valid && rsp_full) |=> back_valid)
      else $error("finished item dropped");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench: self-checking bench for swept_box_collision_test
// depends on sbc_pkg and the block's rtl; compares each result item with a local predictor or a fixed expectation
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import sbc_pkg::*;

   localparam int N_RANDOM = 1050;
   localparam longint CYCLE_LIMIT = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   req_type           req_item = '0;
   logic              empty;
   logic              pop = 1'b0;
   rsp_type           rsp_item;
   logic              csr_write_enable = 1'b0;
   logic [FT_BITS-1:0] csr_write_data = '0;

   // predictor copy of the frame time register
   logic [7:0] frame_ms;
   rsp_type    pending_hits[$];
   int         fail_count = 0;
   longint     cycle_count = 0;
   bit         drain_now = 1'b0;

   swept_box_collision_test i_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // per-frame displacement, 8 fraction bits, truncated toward zero
   function automatic longint frame_disp(logic signed [15:0] speed);
      longint p;
      p = longint'(speed) * longint'(frame_ms) * 256;
      return p / 1000;
   endfunction

   // distance over relative displacement, saturated to +-2.0
   function automatic longint hit_time(longint distance, longint v);
      longint ad, av, q;
      ad = distance < 0 ? -distance : distance;
      av = v < 0 ? -v : v;
      if (ad * 256 >= 2 * av) q = 2 * T_ONE_INT;
      else q = (ad <<< (8 + TIME_FRAC_BITS)) / av;
      return ((distance < 0) != (v < 0)) ? -q : q;
   endfunction

   function automatic rsp_type predict_hit(req_type r);
      longint mdx, mdy, odx, ody, bl, bt, br, bb, vx, vy;
      longint dxe, dxx, dye, dyx, txe, txx, tye, tyx, t_in, t_out;
      rsp_type res;
      res.entry_time = 16'(T_ONE_INT);
      res.hit_side = SIDE_NONE;
      mdx = frame_disp(r.mine_speed_x);
      mdy = frame_disp(r.mine_speed_y);
      odx = frame_disp(r.other_speed_x);
      ody = frame_disp(r.other_speed_y);
      // broadphase: mover box stretched by its own displacement
      bt = longint'(r.mine_top) * 256 + (mdy > 0 ? mdy : 0);
      bb = longint'(r.mine_bottom) * 256 + (mdy > 0 ? 0 : mdy);
      bl = longint'(r.mine_left) * 256 + (mdx > 0 ? 0 : mdx);
      br = longint'(r.mine_right) * 256 + (mdx > 0 ? mdx : 0);
      if (longint'(r.other_left) * 256 - br > 0 || longint'(r.other_right) * 256 - bl < 0 ||
          longint'(r.other_top) * 256 - bb < 0 || longint'(r.other_bottom) * 256 - bt > 0)
         return res;
      vx = mdx - odx;
      vy = mdy - ody;
      if (vx > 0) begin
         dxe = longint'(r.other_left) - r.mine_right;
         dxx = longint'(r.other_right) - r.mine_left;
      end else begin
         dxe = longint'(r.other_right) - r.mine_left;
         dxx = longint'(r.other_left) - r.mine_right;
      end
      if (vy > 0) begin
         dye = longint'(r.other_bottom) - r.mine_top;
         dyx = longint'(r.other_top) - r.mine_bottom;
      end else begin
         dye = longint'(r.other_top) - r.mine_bottom;
         dyx = longint'(r.other_bottom) - r.mine_top;
      end
      // zero motion on an axis stands for infinite times
      if (vx == 0) begin
         txe = -2 * T_ONE_INT; txx = 2 * T_ONE_INT;
      end else begin
         txe = hit_time(dxe, vx); txx = hit_time(dxx, vx);
      end
      if (vy == 0) begin
         tye = -2 * T_ONE_INT; tyx = 2 * T_ONE_INT;
      end else begin
         tye = hit_time(dye, vy); tyx = hit_time(dyx, vy);
      end
      t_in = txe > tye ? txe : tye;
      t_out = txx < tyx ? txx : tyx;
      if (t_in > t_out || (txe < 0 && tye < 0) || txe > T_ONE_INT || tye > T_ONE_INT)
         return res;
      if (txe > tye) res.hit_side = dxe < 0 ? SIDE_RIGHT : SIDE_LEFT;
      else res.hit_side = dye < 0 ? SIDE_TOP : SIDE_BOTTOM;
      res.entry_time = 16'(t_in);
      return res;
   endfunction

   // one directed row: boxes, speeds, typed expectation where obvious
   typedef struct {
      req_type   item;
      bit        fixed;
      rsp_type   hit;
   } row_type;

   row_type rows[$];

   function automatic req_type make_pair(int ml, int mt, int mr, int mb, int ol, int ot,
                                         int orr, int ob, int sx, int sy, int osx, int osy);
      req_type r;
      r.mine_left = 16'(ml); r.mine_top = 16'(mt);
      r.mine_right = 16'(mr); r.mine_bottom = 16'(mb);
      r.other_left = 16'(ol); r.other_top = 16'(ot);
      r.other_right = 16'(orr); r.other_bottom = 16'(ob);
      r.mine_speed_x = 16'(sx); r.mine_speed_y = 16'(sy);
      r.other_speed_x = 16'(osx); r.other_speed_y = 16'(osy);
      return r;
   endfunction

   function automatic void add_row(req_type r, bit fixed = 0, int t = 0,
                                   side_type s = SIDE_NONE);
      row_type w;
      w.item = r; w.fixed = fixed;
      w.hit.entry_time = 16'(t); w.hit.hit_side = s;
      rows.push_back(w);
   endfunction

   // random pair, mostly close boxes that can meet within a frame
   function automatic req_type random_pair();
      req_type r;
      int cx, cy, w, h, gap;
      if ($urandom_range(9) == 0) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return r;
      end
      cx = $urandom_range(2000) - 1000;
      cy = $urandom_range(2000) - 1000;
      w = $urandom_range(60); h = $urandom_range(60);
      r.mine_left = 16'(cx); r.mine_right = 16'(cx + w);
      r.mine_bottom = 16'(cy); r.mine_top = 16'(cy + h);
      gap = $urandom_range(200);
      r.other_left = 16'(cx + $urandom_range(2 * gap) - gap);
      r.other_right = 16'(int'(r.other_left) + $urandom_range(60));
      r.other_bottom = 16'(cy + $urandom_range(2 * gap) - gap);
      r.other_top = 16'(int'(r.other_bottom) + $urandom_range(60));
      if ($urandom_range(15) == 0) r.other_right = 16'(int'(r.other_left) - 5);
      r.mine_speed_x = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8000) - 4000);
      r.mine_speed_y = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8000) - 4000);
      r.other_speed_x = $urandom_range(4) == 0 ? 16'd0 : 16'($urandom_range(4000) - 2000);
      r.other_speed_y = $urandom_range(4) == 0 ? 16'd0 : 16'($urandom_range(4000) - 2000);
      return r;
   endfunction

   // send one item, with burst gaps
   task automatic send_pair(req_type r, bit fixed, rsp_type want);
      int gap;
      if ($urandom_range(3) == 0) begin
         gap = 1 + $urandom_range(5);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_hits.push_back(fixed ? want : predict_hit(r));
   endtask

   task automatic drain_and_write(logic [7:0] ft);
      push <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= ft;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frame_ms = ft;
   endtask

   // receiver with its own stall pattern
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else if (drain_now) pop <= 1'b1;
      else pop <= (cycle_count % 37) < 25 ? ($urandom_range(3) != 0) : ($urandom_range(5) == 0);
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_hits.size() == 0) begin
            $error("result item with nothing expected: %0d %0d",
                   rsp_item.entry_time, rsp_item.hit_side);
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_item.entry_time !== want.entry_time) begin
               $error("entry_time expected %0d actual %0d", want.entry_time,
                      rsp_item.entry_time);
               fail_count++;
            end
            if (rsp_item.hit_side !== want.hit_side) begin
               $error("hit_side expected %0d actual %0d", want.hit_side, rsp_item.hit_side);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("swept_box_collision_test regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      logic [7:0] ft_list[5];
      int k;
      none = '0;
      frame_ms = FT_RESET;
      ft_list = '{8'd0, 8'd255, 8'd1, 8'd33, 8'd16};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: far apart, extremes, stationary contact, each side
      add_row(make_pair(0, 10, 10, 0, 1000, 10, 1010, 0, 0, 0, 0, 0), 1, T_ONE_INT, SIDE_NONE);
      add_row(make_pair(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
                        -32768, -32768, 32767, 32767));
      add_row(make_pair(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767,
                        32767, 32767, -32768, -32768));
      add_row(make_pair(0, 10, 10, 0, 20, 10, 30, 0, 1000, 0, 0, 0));
      add_row(make_pair(20, 10, 30, 0, 0, 10, 10, 0, -1000, 0, 0, 0));
      add_row(make_pair(0, 30, 10, 20, 0, 10, 10, 0, 0, -1000, 0, 0));
      add_row(make_pair(0, 10, 10, 0, 0, 30, 10, 20, 0, 1000, 0, 0));
      add_row(make_pair(0, 10, 10, 0, 10, 10, 20, 0, 0, 0, 0, 0));
      add_row(make_pair(0, 10, 10, 0, 15, 10, 25, 0, 312, 0, -0, 0));
      add_row(make_pair(0, 10, 10, 0, 14, 14, 24, 12, 500, 500, 0, 0));
      add_row(make_pair(0, 10, 10, 0, 20, 10, 30, 0, 1000, 0, 1000, 0));
      add_row(make_pair(0, 10, 10, 0, 20, 10, 30, 0, 100, 0, -5000, 0));
      add_row(make_pair(5, 10, 0, 0, 20, 10, 30, 0, 1000, 0, 0, 0));
      add_row(make_pair(0, 10, 10, 0, -30, 10, -20, 0, 1000, 0, 0, 0));

      for (k = 0; k < rows.size(); k++)
         send_pair(rows[k].item, rows[k].fixed, rows[k].hit);

      // random phases, one per frame time setting
      for (int p = 0; p < 5; p++) begin
         drain_and_write(ft_list[p]);
         for (k = 0; k < N_RANDOM / 5; k++) send_pair(random_pair(), 0, none);
      end

      push <= 1'b0;
      drain_now = 1'b1;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_hits.size() == 0)
         $display("swept_box_collision_test regression: pass");
      else
         $display("swept_box_collision_test regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
